// File: rtl/matrix_multiply_4x4_core_macros.svh
// assertion macros shared by the matrix multiply rtl
// depends on nothing; included by the modules that carry assertions
`ifndef MATRIX_MULTIPLY_4X4_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_4X4_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MM4_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MM4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mm4_pkg.sv
// shared types and constants for the 4x4 fixed-point matrix multiply
// no dependencies; used by mm4_ctrl, mm4_datapath and the top level
`default_nettype none

package mm4_pkg;

    // matrix shape and number format
    localparam int DIM       = 4;
    localparam int CELLS     = DIM * DIM;
    localparam int ELEM_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 4;
    localparam int DIM_W     = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = PROD_W + DIM_W;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_EMIT
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic             wr_en;
        logic             mul_en;
        logic             acc_clr;
        logic             acc_add;
        logic             out_load;
        logic             last;
        logic [DIM_W-1:0] k;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/matrix_multiply_4x4_core.sv
// 4x4 signed q16.16 matrix multiply, column-major operands and results
// per result element: a multiply step for each term on one shared 32x32 multiplier,
//   an add step, then a load into the output word register, which waits while the
//   output is stalled
// input: one word per cycle while idle; busy from go until the last element is loaded
// reset: synchronous, active low; clears both operand stores and the output valid
`default_nettype none

module matrix_multiply_4x4_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_mode,
    input  wire logic        [mm4_pkg::IDX_W-1:0] i_elem_index,
    input  wire logic signed [mm4_pkg::ELEM_W-1:0] i_elem_value,
    input  wire logic                             i_go,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic             [mm4_pkg::IDX_W-1:0] o_out_index,
    output logic signed      [mm4_pkg::ELEM_W-1:0] o_out_value,
    output logic                                  o_saturated,
    output logic                                  o_last
);

    mm4_pkg::t_dp_cmd  w_cmd;
    mm4_pkg::t_dp_stat w_stat;

    // sequencer
    mm4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_go       (i_go),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // stores and arithmetic
    mm4_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_mode       (i_mode),
        .i_elem_index (i_elem_index),
        .i_elem_value (i_elem_value),
        .o_out_index  (o_out_index),
        .o_out_value  (o_out_value),
        .o_saturated  (o_saturated),
        .o_last       (o_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready)
    );

endmodule

`default_nettype wire

// File: rtl/mm4_ctrl.sv
// sequencer for the matrix multiply: input handshake, element and term counters
// depends on mm4_pkg and matrix_multiply_4x4_core_macros.svh
`default_nettype none
`include "matrix_multiply_4x4_core_macros.svh"

module mm4_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_go,
    input  wire mm4_pkg::t_dp_stat i_stat,
    output mm4_pkg::t_dp_cmd       o_cmd
);

    localparam logic [mm4_pkg::DIM_W-1:0] K_MAX = mm4_pkg::DIM_W'(mm4_pkg::DIM - 1);

    mm4_pkg::t_state             r_state, n_state;
    logic [mm4_pkg::DIM_W-1:0]   r_k, n_k;
    logic [mm4_pkg::DIM_W-1:0]   r_row, n_row;
    logic [mm4_pkg::DIM_W-1:0]   r_col, n_col;
    logic                        w_accept;
    logic                        w_last;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_last   = (r_row == K_MAX) && (r_col == K_MAX);

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mm4_pkg::S_IDLE;
            r_k     <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state          = r_state;
        n_k              = r_k;
        n_row            = r_row;
        n_col            = r_col;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.k          = r_k;
        o_cmd.row        = r_row;
        o_cmd.col        = r_col;
        o_cmd.last       = w_last;
        unique case (r_state)
            mm4_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.wr_en = w_accept;
                if (w_accept && i_go) begin
                    n_state = mm4_pkg::S_MUL;
                    n_k     = '0;
                    n_row   = '0;
                    n_col   = '0;
                end
            end
            mm4_pkg::S_MUL: begin
                // one product per cycle, each added to the sum in the following cycle
                o_cmd.mul_en  = 1'b1;
                o_cmd.acc_clr = (r_k == '0);
                o_cmd.acc_add = (r_k != '0);
                if (r_k == K_MAX) begin
                    n_state = mm4_pkg::S_ADD;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            mm4_pkg::S_ADD: begin
                o_cmd.acc_add = 1'b1;
                n_state       = mm4_pkg::S_EMIT;
            end
            mm4_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_k            = '0;
                    if (w_last) begin
                        n_state = mm4_pkg::S_IDLE;
                    end else begin
                        n_state = mm4_pkg::S_MUL;
                        if (r_row == K_MAX) begin
                            n_row = '0;
                            n_col = r_col + 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = mm4_pkg::S_IDLE;
            end
        endcase
    end

    // checks on sequencing
    `MM4_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, o_cmd.out_load, i_stat.out_free, "result loaded into a busy output register")
    `MM4_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, o_cmd.out_load && o_cmd.last, o_in_ready, "not ready after the last element")
    `MM4_ASSERT_NEXT(a_busy_after_go, i_clk, i_rst_n, w_accept && i_go, !o_in_ready, "input taken while a product runs")

endmodule

`default_nettype wire

// File: rtl/mm4_datapath.sv
// operand stores, multiplier, accumulator, shift and clip, output register
// depends on mm4_pkg and matrix_multiply_4x4_core_macros.svh
`default_nettype none
`include "matrix_multiply_4x4_core_macros.svh"

module mm4_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire mm4_pkg::t_dp_cmd                 i_cmd,
    output mm4_pkg::t_dp_stat                     o_stat,
    input  wire logic                             i_mode,
    input  wire logic        [mm4_pkg::IDX_W-1:0] i_elem_index,
    input  wire logic signed [mm4_pkg::ELEM_W-1:0] i_elem_value,
    output logic             [mm4_pkg::IDX_W-1:0] o_out_index,
    output logic signed      [mm4_pkg::ELEM_W-1:0] o_out_value,
    output logic                                  o_saturated,
    output logic                                  o_last,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready
);

    localparam int SH_HI = mm4_pkg::ACC_W - 1;
    localparam int SH_LO = mm4_pkg::ELEM_W - 1;
    localparam logic signed [mm4_pkg::ELEM_W-1:0] MAX_V = {1'b0, {(mm4_pkg::ELEM_W-1){1'b1}}};
    localparam logic signed [mm4_pkg::ELEM_W-1:0] MIN_V = {1'b1, {(mm4_pkg::ELEM_W-1){1'b0}}};

    logic signed [mm4_pkg::ELEM_W-1:0] r_left  [mm4_pkg::CELLS];
    logic signed [mm4_pkg::ELEM_W-1:0] r_right [mm4_pkg::CELLS];
    logic signed [mm4_pkg::PROD_W-1:0] r_prod;
    logic signed [mm4_pkg::ACC_W-1:0]  r_acc;
    logic        [mm4_pkg::ADDR_W-1:0] w_wr_addr;
    logic        [mm4_pkg::ADDR_W-1:0] w_l_addr;
    logic        [mm4_pkg::ADDR_W-1:0] w_r_addr;
    logic signed [mm4_pkg::ELEM_W-1:0] w_l_op;
    logic signed [mm4_pkg::ELEM_W-1:0] w_r_op;
    logic signed [mm4_pkg::PROD_W-1:0] n_prod;
    logic signed [mm4_pkg::ACC_W-1:0]  w_shifted;
    logic        [SH_HI-SH_LO:0]       w_top;
    logic                              w_in_range;
    logic signed [mm4_pkg::ELEM_W-1:0] w_clip;
    logic        [mm4_pkg::IDX_W-1:0]  w_index;

    // operand addresses: left walks a row, right walks a column
    assign w_wr_addr = mm4_pkg::ADDR_W'(i_elem_index);
    assign w_l_addr  = mm4_pkg::ADDR_W'(int'(i_cmd.k) * mm4_pkg::DIM + int'(i_cmd.row));
    assign w_r_addr  = mm4_pkg::ADDR_W'(int'(i_cmd.col) * mm4_pkg::DIM + int'(i_cmd.k));
    assign w_l_op    = r_left[w_l_addr];
    assign w_r_op    = r_right[w_r_addr];
    assign n_prod    = w_l_op * w_r_op;

    // operand stores, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mm4_pkg::CELLS; i++) begin
                r_left[i]  <= '0;
                r_right[i] <= '0;
            end
        end else if (i_cmd.wr_en && (32'(i_elem_index) < mm4_pkg::CELLS)) begin
            if (i_mode) begin
                r_right[w_wr_addr] <= i_elem_value;
            end else begin
                r_left[w_wr_addr] <= i_elem_value;
            end
        end
    end

    // product register and accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + mm4_pkg::ACC_W'(r_prod);
        end
    end

    // floor shift back to the fraction, then clip to the element range
    assign w_shifted  = r_acc >>> mm4_pkg::FRAC_BITS;
    assign w_top      = w_shifted[SH_HI:SH_LO];
    assign w_in_range = (&w_top) || !(|w_top);
    assign w_clip     = w_in_range ? w_shifted[mm4_pkg::ELEM_W-1:0]
                                   : (w_shifted[SH_HI] ? MIN_V : MAX_V);
    assign w_index    = mm4_pkg::IDX_W'(int'(i_cmd.col) * mm4_pkg::DIM + int'(i_cmd.row));

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_index <= w_index;
            o_out_value <= w_clip;
            o_saturated <= !w_in_range;
            o_last      <= i_cmd.last;
        end
    end

    assign o_stat.out_free = !o_out_valid || i_out_ready;

    // checks on the result path
    `MM4_ASSERT_NEXT(a_valid_after_load, i_clk, i_rst_n, i_cmd.out_load, o_out_valid, "loaded word not shown")
    `MM4_ASSERT_NOW(a_sat_value, i_clk, i_rst_n, o_out_valid && o_saturated, (o_out_value == MAX_V) || (o_out_value == MIN_V), "clipped word is not a range limit")
    `MM4_ASSERT_NOW(a_last_index, i_clk, i_rst_n, o_out_valid && o_last, o_out_index == mm4_pkg::IDX_W'(mm4_pkg::CELLS - 1), "last flag on a word other than the final one")

endmodule

`default_nettype wire
